// File: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and codes for the software timer slot table: slot kinds,
// opcodes, error codes, controller states and the per-item result record.
// ----------------------------------------------------------------------------
package sts_pkg;

	// Slot kind; zero marks an unallocated slot
	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_INTERVAL = 2'd1,
		KIND_ONESHOT  = 2'd2
	} kind_t;

	// Operation codes carried by an input transfer
	localparam logic [2:0] OP_POLL    = 3'd0;
	localparam logic [2:0] OP_START   = 3'd1;
	localparam logic [2:0] OP_RESTART = 3'd2;
	localparam logic [2:0] OP_CANCEL  = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;

	// Sticky error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_MISMATCH = 2'd1;
	localparam logic [1:0] ERR_FULL     = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Result of one item as built during the scan
	typedef struct packed {
		logic        found;
		logic        fired;
		logic        running;
		logic        done;
		logic [31:0] elapsed;
		logic [31:0] remaining;
	} res_t;

endpackage

// File: sv/sts_cell.sv
// ----------------------------------------------------------------------------
// sts_cell
// One timer slot of the ring. Takes the record of its neighbor on every
// shift cycle, so the whole table rotates past the head once per item.
// ----------------------------------------------------------------------------
module sts_cell #(
	parameter int ID_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  logic [ID_WIDTH-1:0]   id_in,
	input  sts_pkg::kind_t        kind_in,
	input  logic [31:0]           start_in,
	input  logic [31:0]           period_in,
	input  logic                  active_in,
	output logic [ID_WIDTH-1:0]   id_out,
	output sts_pkg::kind_t        kind_out,
	output logic [31:0]           start_out,
	output logic [31:0]           period_out,
	output logic                  active_out
);
	import sts_pkg::*;

	logic [ID_WIDTH-1:0] id_q;
	kind_t               kind_q;
	logic [31:0]         start_q;
	logic [31:0]         period_q;
	logic                active_q;

	// control bits of the slot: cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_NONE;
			active_q <= 1'b0;
		end else if (shift_en) begin
			kind_q   <= kind_in;
			active_q <= active_in;
		end
	end

	// payload: only read once the slot is allocated or active
	always_ff @(posedge clk) begin
		if (shift_en) begin
			id_q     <= id_in;
			start_q  <= start_in;
			period_q <= period_in;
		end
	end

	assign id_out     = id_q;
	assign kind_out   = kind_q;
	assign start_out  = start_q;
	assign period_out = period_q;
	assign active_out = active_q;

endmodule

// File: sv/sts_op.sv
// ----------------------------------------------------------------------------
// sts_op
// Head-of-ring update. Checks the slot at the head against the pending
// item, allocates it if it is the first free slot, applies the opcode and
// hands the updated record to the tail of the ring.
// ----------------------------------------------------------------------------
module sts_op #(
	parameter int ID_WIDTH = 16
) (
	input  logic                  pending,
	input  logic [2:0]            opcode,
	input  logic [ID_WIDTH-1:0]   key,
	input  logic [31:0]           span_ms,
	input  logic [31:0]           now_ms,
	input  logic [ID_WIDTH-1:0]   id_in,
	input  sts_pkg::kind_t        kind_in,
	input  logic [31:0]           start_in,
	input  logic [31:0]           period_in,
	input  logic                  active_in,
	output logic [ID_WIDTH-1:0]   id_out,
	output sts_pkg::kind_t        kind_out,
	output logic [31:0]           start_out,
	output logic [31:0]           period_out,
	output logic                  active_out,
	output logic                  take,
	output logic                  mismatch,
	output sts_pkg::res_t         res
);
	import sts_pkg::*;

	logic        matched;
	logic        free;
	kind_t       want;
	logic [31:0] elapsed;
	logic        expired;

	// slot selection: allocated slots form a prefix, so the first free one
	// is reached only after every possible match has gone by
	assign matched  = (kind_in != KIND_NONE) && (id_in == key);
	assign free     = (kind_in == KIND_NONE);
	assign want     = (opcode == OP_POLL) ? KIND_INTERVAL : KIND_ONESHOT;
	assign take     = pending && (matched || free);
	assign mismatch = take && matched && (kind_in != want);

	// wrap-safe time since start
	assign elapsed = now_ms - start_in;
	assign expired = (elapsed >= period_in);

	// record update and result
	always_comb begin
		id_out     = id_in;
		kind_out   = kind_in;
		start_out  = start_in;
		period_out = period_in;
		active_out = active_in;
		res        = '0;
		if (take) begin
			res.found = 1'b1;
			if (free) begin
				id_out   = key;
				kind_out = want;
			end
			unique case (opcode)
				OP_POLL: begin
					if (!active_in) begin
						period_out = span_ms;
						start_out  = now_ms;
						active_out = 1'b1;
					end else if (expired) begin
						start_out = start_in + period_in;
						res.fired = 1'b1;
					end
				end
				OP_START: begin
					period_out = span_ms;
					start_out  = now_ms;
					active_out = 1'b1;
				end
				OP_RESTART: begin
					if (active_in) start_out = now_ms;
				end
				OP_CANCEL: begin
					active_out = 1'b0;
				end
				OP_QUERY: begin
					if (active_in) begin
						res.elapsed = elapsed;
						if (expired) begin
							res.done = 1'b1;
						end else begin
							res.running   = 1'b1;
							res.remaining = period_in - elapsed;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: sv/software_timer_slot_table_core.sv
// Each item is taken in the idle state, rotates the slot ring once past the
// head unit (undefined opcodes skip the rotation) and is then loaded into
// the output register; no new item is taken until that load is done.
// A finished result waits in the output register while the next item runs.
// Reset (arst_n, async, active low) frees all slots and clears the error.
// ----------------------------------------------------------------------------
// software_timer_slot_table_core
// Timer slot table built as a ring of slot cells. Each item rotates the
// ring once; the head unit looks up or allocates the slot and updates it.
// ----------------------------------------------------------------------------
module software_timer_slot_table_core #(
	parameter int SLOT_COUNT = 32,
	parameter int ID_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] timer_id,
	input  logic [31:0] span_ms,
	input  logic [31:0] now_ms,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        slot_found,
	output logic        interval_fired,
	output logic        is_running,
	output logic        is_done,
	output logic [31:0] elapsed_ms,
	output logic [31:0] remaining_ms,
	output logic [1:0]  last_error
);
	import sts_pkg::*;

	localparam int              CW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [CW-1:0]   CNT_LAST = CW'(SLOT_COUNT - 1);

	// ring wiring
	logic [ID_WIDTH-1:0] id_w     [SLOT_COUNT];
	kind_t               kind_w   [SLOT_COUNT];
	logic [31:0]         start_w  [SLOT_COUNT];
	logic [31:0]         period_w [SLOT_COUNT];
	logic                active_w [SLOT_COUNT];

	logic [ID_WIDTH-1:0] id_t;
	kind_t               kind_t_w;
	logic [31:0]         start_t;
	logic [31:0]         period_t;
	logic                active_t;

	// controller
	state_t              state_q, state_nx;
	logic [CW-1:0]       cnt_q;
	logic                shift_en;
	logic                out_load;
	logic                accept;
	logic                out_free;

	// captured item
	logic [2:0]          op_q;
	logic [ID_WIDTH-1:0] key_q;
	logic [31:0]         dur_q;
	logic [31:0]         now_q;
	logic                pending_q;
	logic                op_ok_q;
	res_t                res_q;
	logic [1:0]          err_q;
	logic [1:0]          err_nx;
	logic                full;

	// head unit outputs
	logic                take;
	logic                mismatch;
	res_t                res_w;

	logic [ID_WIDTH+15:0] key_ext;

	// output register
	logic                out_valid_q;
	logic                found_q, fired_q, running_q, done_q;
	logic [31:0]         elapsed_q, remaining_q;
	logic [1:0]          last_error_q;

	// only the low ID_WIDTH bits of the id count
	assign key_ext = {ID_WIDTH'(0), timer_id};

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ring of slot cells: cell 0 is the head, the head unit feeds the tail
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == SLOT_COUNT - 1) begin : g_tail
			sts_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift_en   (shift_en),
				.id_in      (id_t),
				.kind_in    (kind_t_w),
				.start_in   (start_t),
				.period_in  (period_t),
				.active_in  (active_t),
				.id_out     (id_w[i]),
				.kind_out   (kind_w[i]),
				.start_out  (start_w[i]),
				.period_out (period_w[i]),
				.active_out (active_w[i])
			);
		end else begin : g_body
			sts_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift_en   (shift_en),
				.id_in      (id_w[i+1]),
				.kind_in    (kind_w[i+1]),
				.start_in   (start_w[i+1]),
				.period_in  (period_w[i+1]),
				.active_in  (active_w[i+1]),
				.id_out     (id_w[i]),
				.kind_out   (kind_w[i]),
				.start_out  (start_w[i]),
				.period_out (period_w[i]),
				.active_out (active_w[i])
			);
		end
	end

	// head unit
	sts_op #(.ID_WIDTH(ID_WIDTH)) u_op (
		.pending     (pending_q),
		.opcode      (op_q),
		.key         (key_q),
		.span_ms     (dur_q),
		.now_ms      (now_q),
		.id_in       (id_w[0]),
		.kind_in     (kind_w[0]),
		.start_in    (start_w[0]),
		.period_in   (period_w[0]),
		.active_in   (active_w[0]),
		.id_out      (id_t),
		.kind_out    (kind_t_w),
		.start_out   (start_t),
		.period_out  (period_t),
		.active_out  (active_t),
		.take        (take),
		.mismatch    (mismatch),
		.res         (res_w)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = (opcode <= OP_QUERY) ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (cnt_q == CNT_LAST) state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		in_stall = 1'b1;
		shift_en = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_SCAN: shift_en = 1'b1;
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	// item capture and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pending_q <= 1'b0;
			op_ok_q   <= 1'b0;
		end else if (accept) begin
			cnt_q     <= '0;
			pending_q <= (opcode <= OP_QUERY);
			op_ok_q   <= (opcode <= OP_QUERY);
		end else if (shift_en) begin
			cnt_q <= cnt_q + CW'(1);
			if (take) pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			key_q <= key_ext[ID_WIDTH-1:0];
			dur_q <= span_ms;
			now_q <= now_ms;
			res_q <= '0;
		end else if (shift_en && take) begin
			res_q <= res_w;
		end
	end

	// sticky error: mismatch seen at the head, full after a fruitless scan
	assign full   = op_ok_q && pending_q;
	assign err_nx = full ? ERR_FULL : err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= ERR_NONE;
		end else if (shift_en && mismatch) begin
			err_q <= ERR_MISMATCH;
		end else if (out_load) begin
			err_q <= err_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q      <= res_q.found;
			fired_q      <= res_q.fired;
			running_q    <= res_q.running;
			done_q       <= res_q.done;
			elapsed_q    <= res_q.elapsed;
			remaining_q  <= res_q.remaining;
			last_error_q <= err_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign slot_found     = found_q;
	assign interval_fired = fired_q;
	assign is_running     = running_q;
	assign is_done        = done_q;
	assign elapsed_ms     = elapsed_q;
	assign remaining_ms   = remaining_q;
	assign last_error     = last_error_q;

	// a scan runs the full rotation before finishing
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && (cnt_q != CNT_LAST) |=> (state_q == ST_SCAN))
		else $error("scan left before full rotation");

	// an item is handled by at most one slot
	a_single_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !(pending_q && res_q.found))
		else $error("item both pending and found");

	// the error register never returns to no error
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |=> (err_q != ERR_NONE))
		else $error("sticky error cleared");

	// table full is only reported when the last slot is allocated
	a_full_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && full |-> (kind_w[SLOT_COUNT-1] != KIND_NONE))
		else $error("table full with a free slot");

endmodule
